[design/lrusc_pkg.sv]
package lrusc_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W      = 3;
    localparam int KEY_W      = 64;
    localparam int STS_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 24;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FILL   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INVAL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;
    localparam logic [STAMP_W-1:0]   EXPIRY_RST  = 32'd30;
    localparam logic [STS_W-1:0]     TIMEOUT_RST = 16'hFFFF;
    localparam logic [STAMP_W-1:0]   STAMP_MAX   = 32'hFFFF_FFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic eval;      // register match, empty and expired searches
        logic act;       // apply the request
        logic scan_clr;  // restart the least recently used scan
        logic scan;      // advance the scan
        logic fill_lru;  // write the fill into the scan winner
        logic load_out;  // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             drop;
        logic             fill_ready;
        logic             scan_done;
        logic             out_free;
    } stat_t;

endpackage

[design/lrusc_ctrl.sv]
module lrusc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lrusc_pkg::stat_t  stat,
    output lrusc_pkg::cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_ACT  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_FILL = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Sequence one transaction through the datapath
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT: begin
                cmd.act = 1'b1;
                if (stat.req == lrusc_pkg::REQ_FILL && !stat.drop && !stat.fill_ready) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_lru = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/lrusc_dp.sv]
module lrusc_dp #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [lrusc_pkg::REQ_W-1:0]        in_req,
    input  logic [lrusc_pkg::KEY_W-1:0]        in_key,
    input  logic [lrusc_pkg::STS_W-1:0]        in_status,
    input  logic                               cfg_valid,
    input  logic [lrusc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrusc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [lrusc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  lrusc_pkg::cmd_t                    cmd,
    output lrusc_pkg::stat_t                   stat
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);
    localparam int STS_W   = lrusc_pkg::STS_W;
    localparam int STAMP_W = lrusc_pkg::STAMP_W;

    // Captured transaction
    logic [lrusc_pkg::REQ_W-1:0] req_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [STS_W-1:0]            stin_reg;

    // Configuration and global counters
    logic [STAMP_W-1:0] expiry_reg;
    logic [STS_W-1:0]   timeout_reg;
    logic [STAMP_W-1:0] use_cnt_reg;
    logic [STAMP_W-1:0] now_reg;

    // Entry lanes compared in parallel
    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_BITS-1:0] lane_key_reg [ENTRIES];
    logic [STAMP_W-1:0]  lane_ts_reg  [ENTRIES];

    // Entry memories
    logic [STS_W-1:0]   status_mem [ENTRIES];
    logic [STAMP_W-1:0] use_mem    [ENTRIES];
    logic [STS_W-1:0]   sts_rd_reg;
    logic [STAMP_W-1:0] use_rd_reg;

    // Search results
    logic             match_found_reg, live_reg, fill_ready_reg, drop_reg;
    logic [IDX_W-1:0] match_idx_reg, fill_idx_reg;

    // Least recently used scan
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    // Result and output register
    logic                            res_hit_reg, res_sts_en_reg, res_stored_reg;
    logic                            m_tvalid_reg;
    logic [lrusc_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [ENTRIES-1:0] match_vec, exp_vec;
    logic               m_found, e_found, x_found;
    logic [IDX_W-1:0]   m_idx, e_idx, x_idx;
    logic               lu_wr, fa_wr, fl_wr, fill_wr, any_wr;
    logic [IDX_W-1:0]   wr_idx;
    logic [STAMP_W-1:0] use_next;
    logic               scan_issue;

    // Search all lanes for key match, empty and expired slots
    always_comb begin
        m_found = 1'b0;
        e_found = 1'b0;
        x_found = 1'b0;
        m_idx   = '0;
        e_idx   = '0;
        x_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (lane_key_reg[i] == key_reg);
            exp_vec[i]   = (now_reg - lane_ts_reg[i]) >= expiry_reg;
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                m_found = 1'b1;
                m_idx   = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                e_found = 1'b1;
                e_idx   = IDX_W'(i);
            end
            if (valid_reg[i] && exp_vec[i]) begin
                x_found = 1'b1;
                x_idx   = IDX_W'(i);
            end
        end
    end

    // Decode writes for this cycle
    always_comb begin
        lu_wr      = cmd.act && req_reg == lrusc_pkg::REQ_LOOKUP && live_reg;
        fa_wr      = cmd.act && req_reg == lrusc_pkg::REQ_FILL && !drop_reg && fill_ready_reg;
        fl_wr      = cmd.fill_lru;
        fill_wr    = fa_wr || fl_wr;
        any_wr     = lu_wr || fill_wr;
        use_next   = (use_cnt_reg == lrusc_pkg::STAMP_MAX) ? use_cnt_reg : use_cnt_reg + 1'b1;
        scan_issue = cmd.scan && (scan_cnt_reg != SCAN_END);
        priority if (fl_wr) begin
            wr_idx = best_idx_reg;
        end else if (fa_wr) begin
            wr_idx = fill_idx_reg;
        end else begin
            wr_idx = match_idx_reg;
        end
    end

    // Capture the transaction and the search results
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= in_req;
            key_reg  <= in_key[KEY_BITS-1:0];
            stin_reg <= in_status;
        end
        if (cmd.eval) begin
            match_found_reg <= m_found;
            match_idx_reg   <= m_idx;
            live_reg        <= |(match_vec & ~exp_vec);
            drop_reg        <= (stin_reg == timeout_reg);
            fill_ready_reg  <= m_found || e_found || x_found;
            priority if (m_found) begin
                fill_idx_reg <= m_idx;
            end else if (e_found) begin
                fill_idx_reg <= e_idx;
            end else begin
                fill_idx_reg <= x_idx;
            end
        end
    end

    // Configuration, time and use counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg  <= lrusc_pkg::EXPIRY_RST;
            timeout_reg <= lrusc_pkg::TIMEOUT_RST;
            use_cnt_reg <= '0;
            now_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_index == lrusc_pkg::CFG_EXPIRY) begin
                expiry_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == lrusc_pkg::CFG_TIMEOUT) begin
                timeout_reg <= cfg_data[STS_W-1:0];
            end
            if (any_wr) begin
                use_cnt_reg <= use_next;
            end
            if (cmd.act && req_reg == lrusc_pkg::REQ_TICK) begin
                now_reg <= now_reg + 1'b1;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.act && req_reg == lrusc_pkg::REQ_INVAL) begin
            valid_reg <= '0;
        end else if (cmd.act && req_reg == lrusc_pkg::REQ_CLEAR && match_found_reg) begin
            valid_reg[match_idx_reg] <= 1'b0;
        end else if (fill_wr) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Lane keys and time stamps
    always_ff @(posedge aclk) begin
        if (any_wr) begin
            lane_ts_reg[wr_idx] <= now_reg;
        end
        if (fill_wr) begin
            lane_key_reg[wr_idx] <= key_reg;
        end
    end

    // Status and use stamp memories
    always_ff @(posedge aclk) begin
        if (fill_wr) begin
            status_mem[wr_idx] <= stin_reg;
        end
        if (any_wr) begin
            use_mem[wr_idx] <= use_next;
        end
        sts_rd_reg <= status_mem[match_idx_reg];
        use_rd_reg <= use_mem[scan_cnt_reg[IDX_W-1:0]];
    end

    // Walk the use stamps for the lowest one, lowest index on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else if (cmd.scan_clr) begin
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else if (cmd.scan) begin
            rd_vld_reg <= scan_issue;
            if (scan_issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
        if (cmd.scan && rd_vld_reg && (rd_idx_reg == '0 || use_rd_reg < best_reg)) begin
            best_reg     <= use_rd_reg;
            best_idx_reg <= rd_idx_reg;
        end
    end

    // Result flags
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_hit_reg    <= 1'b0;
            res_sts_en_reg <= 1'b0;
            res_stored_reg <= 1'b0;
        end else begin
            if (lu_wr) begin
                res_hit_reg    <= 1'b1;
                res_sts_en_reg <= 1'b1;
            end
            if (cmd.act && req_reg == lrusc_pkg::REQ_CLEAR && match_found_reg) begin
                res_hit_reg <= 1'b1;
            end
            if (fill_wr) begin
                res_stored_reg <= 1'b1;
            end
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {6'b0, res_stored_reg,
                            res_sts_en_reg ? sts_rd_reg : {STS_W{1'b0}}, res_hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stat.req        = req_reg;
        stat.drop       = drop_reg;
        stat.fill_ready = fill_ready_reg;
        stat.scan_done  = (scan_cnt_reg == SCAN_END) && !rd_vld_reg;
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

[design/lru_status_cache_with_expiry_core.sv]
// Channel   Handshake            Payload
// s_        s_tvalid/s_tready    s_tuser: req_type; s_tdata: key, status_in
// m_        m_tvalid/m_tready    m_tdata: hit, status_out, stored
// cfg_      cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// A request passes through capture, search, apply and output load steps. A fill
// that finds no matching, empty or expired slot walks the use stamp memory one
// entry a cycle between its apply and output load steps.
// One request is in flight at a time; the next is accepted while a result
// waits in the output register. A stalled m_ side holds the block in its
// output load step. Reset is synchronous, active low, and clears all valid bits.
module lru_status_cache_with_expiry_core #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lrusc_pkg::S_TDATA_W-1:0]       s_tdata,   // key[63:0], status_in[79:64]
    input  logic [lrusc_pkg::REQ_W-1:0]           s_tuser,   // req_type[2:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lrusc_pkg::M_TDATA_W-1:0]       m_tdata,   // hit[0], status_out[16:1],
                                                             // stored[17], zero[23:18]
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lrusc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lrusc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lrusc_pkg::cmd_t  cmd;
    lrusc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    lrusc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrusc_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_req    (s_tuser),
        .in_key    (s_tdata[63:0]),
        .in_status (s_tdata[79:64]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    // Only one request in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // No result before the search and apply steps
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !cmd.load_out ##1 !cmd.load_out)
        else $error("result loaded before request was applied");

    // Result is loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("output register overwritten");

    // Scan winner written only after the scan finished
    a_fill_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_lru |-> $past(stat.scan_done))
        else $error("fill written before scan completed");
`endif

endmodule

[sim/lru_status_cache_with_expiry_core_tb.sv]
module lru_status_cache_with_expiry_core_tb;
    import lrusc_pkg::*;

    localparam int SLOTS         = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 150;
    localparam int MAX_PRINTS    = 40;
    localparam int KEY_POOL_SIZE = 32;
    localparam int PHASES        = 6;
    localparam int HOLD_PHASE    = 1;
    localparam int PAUSE_PHASE   = 2;

    // Request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_RSV_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSV_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSV_HI  = 3'd7;

    localparam logic [KEY_W-1:0] KEY_CHK    = 64'h5A5A_5A5A_5A5A_5A5A;
    localparam logic [KEY_W-1:0] KEY_ABSENT = 64'h0000_1234_0000_5678;
    localparam logic [KEY_W-1:0] KEY_A      = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [KEY_W-1:0] KEY_5      = 64'h5555_5555_5555_5555;

    typedef struct packed {
        logic             hit;
        logic [STS_W-1:0] status;
        logic             stored;
    } cache_reply_t;

    localparam cache_reply_t NO_REPLY     = '0;
    localparam cache_reply_t HIT_NO_DATA  = '{hit: 1'b1, status: '0, stored: 1'b0};
    localparam cache_reply_t STORED_REPLY = '{hit: 1'b0, status: '0, stored: 1'b1};

    typedef struct {
        bit                    is_cfg;
        logic [REQ_W-1:0]      req;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [KEY_W-1:0]      key;
        logic [CFG_DATA_W-1:0] value;
        bit                    typed;
        cache_reply_t          want;
    } plan_row_t;

    typedef struct {
        logic [STAMP_W-1:0] expiry;
        bit                 fixed_timeout;
        logic [STS_W-1:0]   timeout;
        int                 key_span;
        int                 tick_pct;
        int                 count;
    } phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // key[63:0], status_in[79:64]
    logic [REQ_W-1:0]      s_tuser;   // req_type[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // hit[0], status_out[16:1], stored[17], zero[23:18]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Typed expectation riding along with the transaction on the input side
    bit                    row_typed;
    cache_reply_t          row_want;

    // Cache shadow
    bit                    slot_valid  [SLOTS];
    logic [KEY_W-1:0]      slot_key    [SLOTS];
    logic [STS_W-1:0]      slot_status [SLOTS];
    logic [STAMP_W-1:0]    slot_used   [SLOTS];
    logic [STAMP_W-1:0]    slot_born   [SLOTS];
    logic [STAMP_W-1:0]    use_count;
    logic [STAMP_W-1:0]    now_ticks;
    logic [STAMP_W-1:0]    expiry_cfg;
    logic [STS_W-1:0]      timeout_cfg;

    cache_reply_t          pending_replies [$];
    int                    sent_count;
    int                    checked_count;
    int                    errors;
    int                    hit_count;
    int                    store_count;
    int                    cfg_writes;
    int                    long_holds;
    int                    cycle_count;
    int                    hold_left;
    bit                    hold_req;
    bit                    gaps_on;

    lru_status_cache_with_expiry_core #(
        .ENTRIES  (SLOTS),
        .KEY_BITS (KEY_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cache shadow: searches, replacement choice and request handling

    function automatic int find_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic bit slot_stale(int i);
        logic [STAMP_W-1:0] age;
        age = now_ticks - slot_born[i];
        return age >= expiry_cfg;
    endfunction

    // Use counter sticks at its maximum
    function automatic logic [STAMP_W-1:0] bump_use();
        if (use_count != STAMP_MAX)
            use_count = use_count + 1'b1;
        return use_count;
    endfunction

    // Same key, then first empty, then first expired, then least recently used
    function automatic int choose_victim(logic [KEY_W-1:0] key);
        int best;
        best = find_slot(key);
        if (best >= 0)
            return best;
        for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i])
                return i;
        for (int i = 0; i < SLOTS; i++)
            if (slot_stale(i))
                return i;
        best = 0;
        for (int i = 1; i < SLOTS; i++)
            if (slot_used[i] < slot_used[best])
                best = i;
        return best;
    endfunction

    function automatic cache_reply_t predict_request(logic [REQ_W-1:0] req,
                                                     logic [KEY_W-1:0] key,
                                                     logic [STS_W-1:0] sts);
        cache_reply_t reply;
        int           idx;
        reply = NO_REPLY;
        case (req)
            REQ_LOOKUP: begin
                idx = find_slot(key);
                // an expired slot misses and stays untouched
                if (idx >= 0 && !slot_stale(idx)) begin
                    reply.hit      = 1'b1;
                    reply.status   = slot_status[idx];
                    slot_used[idx] = bump_use();
                    slot_born[idx] = now_ticks;
                end
            end
            REQ_FILL: begin
                if (sts != timeout_cfg) begin
                    idx              = choose_victim(key);
                    slot_valid[idx]  = 1'b1;
                    slot_key[idx]    = key;
                    slot_status[idx] = sts;
                    slot_born[idx]   = now_ticks;
                    slot_used[idx]   = bump_use();
                    reply.stored     = 1'b1;
                end
            end
            REQ_CLEAR: begin
                idx = find_slot(key);
                if (idx >= 0) begin
                    slot_valid[idx] = 1'b0;
                    reply.hit       = 1'b1;
                end
            end
            REQ_INVAL: begin
                for (int i = 0; i < SLOTS; i++)
                    slot_valid[i] = 1'b0;
            end
            REQ_TICK: begin
                now_ticks = now_ticks + 1'b1;
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    function automatic plan_row_t mk_req(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                         logic [STS_W-1:0] sts, bit typed,
                                         cache_reply_t want);
        plan_row_t row;
        row         = '{default: '0};
        row.req     = req;
        row.key     = key;
        row.value   = {16'h0, sts};
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic plan_row_t mk_cfg(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH %s at result %0d: got %0h, expected %0h",
                     what, checked_count, got, want);
    endtask

    // Offer one request and hold it until accepted, then maybe idle a burst
    task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                logic [STS_W-1:0] sts, bit typed, cache_reply_t want);
        s_tvalid  <= 1'b1;
        s_tuser   <= req;
        s_tdata   <= {sts, key};
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sent_count++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every accepted request has answered
    task automatic settle_results(int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (checked_count < sent_count);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        settle_results(4);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Result check, request prediction and register tracking at each edge
    always @(posedge aclk) begin : transaction_monitor
        cache_reply_t got;
        cache_reply_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.hit    = m_tdata[0];
                got.status = m_tdata[16:1];
                got.stored = m_tdata[17];
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.status !== want.status)
                        report_mismatch("status_out", 64'(got.status), 64'(want.status));
                    if (got.stored !== want.stored)
                        report_mismatch("stored", 64'(got.stored), 64'(want.stored));
                end
                if (m_tdata[23:18] !== '0)
                    report_mismatch("padding", 64'(m_tdata[23:18]), 64'd0);
                checked_count++;
                hit_count   += int'(got.hit);
                store_count += int'(got.stored);
            end
            if (s_tvalid && s_tready) begin
                want = predict_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[S_TDATA_W-1:KEY_W]);
                pending_replies.push_back(row_typed ? row_want : want);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EXPIRY:  expiry_cfg  = cfg_data;
                    CFG_TIMEOUT: timeout_cfg = cfg_data[STS_W-1:0];
                    default: begin
                    end
                endcase
                cfg_writes++;
            end
        end
    end

    // Result side: random short stalls, plus one long hold on request
    initial begin
        m_tready  <= 1'b0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = LONG_HOLD - 1;
                long_holds++;
                m_tready  <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                hold_left  = $urandom_range(0, 3);
                m_tready  <= 1'b0;
            end else begin
                m_tready  <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("lru_status_cache_with_expiry_core_tb: done, errors");
        $finish;
    end

    initial begin
        plan_row_t          plan [$];
        phase_t             phases [PHASES];
        logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
        logic [REQ_W-1:0]   req;
        logic [KEY_W-1:0]   key;
        logic [STS_W-1:0]   sts;
        logic [STS_W-1:0]   phase_timeout;
        int                 r;

        // Drive every input and clear the shadow state
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_LOOKUP;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_EXPIRY;
        cfg_data  <= '0;
        row_typed <= 1'b0;
        row_want  <= NO_REPLY;
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i]  = 1'b0;
            slot_key[i]    = '0;
            slot_status[i] = '0;
            slot_used[i]   = '0;
            slot_born[i]   = '0;
        end
        use_count     = '0;
        now_ticks     = '0;
        expiry_cfg    = EXPIRY_RST;
        timeout_cfg   = TIMEOUT_RST;
        sent_count    = 0;
        checked_count = 0;
        errors        = 0;
        hit_count     = 0;
        store_count   = 0;
        cfg_writes    = 0;
        long_holds    = 0;
        hold_req      = 1'b0;
        gaps_on       = 1'b1;

        // Directed walk: reset values first, then short expiry, then zero expiry
        plan.push_back(mk_req(REQ_LOOKUP, '0, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_FILL, '0, '0, 1'b1, STORED_REPLY));
        plan.push_back(mk_req(REQ_FILL, '1, 16'hFFFE, 1'b1, STORED_REPLY));
        // timeout code is never stored
        plan.push_back(mk_req(REQ_FILL, KEY_CHK, TIMEOUT_RST, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, '0, 16'hFFFF, 1'b0, NO_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, '1, '0, 1'b0, NO_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, KEY_CHK, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_CLEAR, KEY_ABSENT, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_CLEAR, '0, '0, 1'b1, HIT_NO_DATA));
        plan.push_back(mk_req(REQ_LOOKUP, '0, '0, 1'b1, NO_REPLY));
        // refill of a present key overwrites its slot
        plan.push_back(mk_req(REQ_FILL, '1, 16'h0001, 1'b0, NO_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, '1, '0, 1'b0, NO_REPLY));
        plan.push_back(mk_req(REQ_TICK, '0, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_RSV_LO, '0, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_RSV_MID, '1, 16'hFFFF, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_RSV_HI, KEY_CHK, 16'h8001, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_INVAL, '1, '1, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, '1, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_cfg(CFG_EXPIRY, 32'd1));
        plan.push_back(mk_req(REQ_FILL, KEY_A, 16'h5555, 1'b1, STORED_REPLY));
        plan.push_back(mk_req(REQ_LOOKUP, KEY_A, '0, 1'b0, NO_REPLY));
        plan.push_back(mk_req(REQ_TICK, '0, '0, 1'b1, NO_REPLY));
        // one tick old with expiry of one: miss, slot left alone
        plan.push_back(mk_req(REQ_LOOKUP, KEY_A, '0, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_FILL, KEY_5, 16'hAAAA, 1'b0, NO_REPLY));
        plan.push_back(mk_cfg(CFG_EXPIRY, 32'd0));
        plan.push_back(mk_cfg(CFG_TIMEOUT, 32'd0));
        plan.push_back(mk_req(REQ_FILL, 64'd1, 16'h0000, 1'b1, NO_REPLY));
        plan.push_back(mk_req(REQ_FILL, 64'd1, 16'hFFFF, 1'b1, STORED_REPLY));
        // zero expiry: every lookup misses
        plan.push_back(mk_req(REQ_LOOKUP, 64'd1, '0, 1'b1, NO_REPLY));

        phases[0] = '{EXPIRY_RST,    1'b1, TIMEOUT_RST, 20, 10, 300};
        phases[1] = '{STAMP_MAX,     1'b1, 16'h0000,    24,  5, 300};
        phases[2] = '{32'd3,         1'b0, 16'h0000,    20, 20, 300};
        phases[3] = '{32'd1,         1'b0, 16'h0000,    14, 15, 250};
        phases[4] = '{32'd0,         1'b0, 16'h0000,    20,  5, 150};
        phases[5] = '{32'd17,        1'b0, 16'h0000,    22, 12, 400};

        // Keys: extremes, random, and near neighbors differing in one bit
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = (i % 4 == 3) ? key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63))
                                       : {$urandom, $urandom};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].value);
            else
                send_request(plan[i].req, plan[i].key, plan[i].value[STS_W-1:0],
                             plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            phase_timeout = phases[p].fixed_timeout ? phases[p].timeout
                                                    : STS_W'($urandom_range(0, 16'hFFFF));
            write_reg(CFG_EXPIRY, phases[p].expiry);
            write_reg(CFG_TIMEOUT, {16'h0, phase_timeout});
            gaps_on = (p != PHASES - 1);
            for (int n = 0; n < phases[p].count; n++) begin
                if (p == HOLD_PHASE && n == 40)
                    hold_req = 1'b1;
                if (p == PAUSE_PHASE && n == 150)
                    settle_results(0);
                r   = $urandom_range(0, 99);
                key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0,
                                                             phases[p].key_span - 1)];
                case ($urandom_range(0, 9))
                    0:       sts = phase_timeout;
                    1:       sts = '0;
                    2:       sts = '1;
                    default: sts = STS_W'($urandom);
                endcase
                if (r < 36)
                    req = REQ_LOOKUP;
                else if (r < 66)
                    req = REQ_FILL;
                else if (r < 74)
                    req = REQ_CLEAR;
                else if (r < 74 + phases[p].tick_pct)
                    req = REQ_TICK;
                else if (r == 99)
                    req = REQ_INVAL;
                else if (r == 98)
                    req = REQ_RSV_LO;
                else if (r == 97)
                    req = $urandom_range(0, 1) ? REQ_RSV_MID : REQ_RSV_HI;
                else
                    req = REQ_LOOKUP;
                send_request(req, key, sts, 1'b0, NO_REPLY);
            end
        end

        settle_results(SETTLE_CYCLES);
        if (pending_replies.size() != 0)
            report_mismatch("results never returned", 64'(pending_replies.size()), 64'd0);

        $display("covered %0d requests and %0d register writes; %0d results: %0d hits, %0d stores",
                 sent_count, cfg_writes, checked_count, hit_count, store_count);
        $display("expiry 0, 1, 3, 17, 30 and max with full-cache eviction; %0d long output hold(s)",
                 long_holds);
        if (errors == 0)
            $display("lru_status_cache_with_expiry_core_tb: done, clean");
        else
            $display("lru_status_cache_with_expiry_core_tb: done, errors");
        $finish;
    end

endmodule
